/* src/bbpd_pkg.sv */
// Package for the binary boundary pixel detector.
// Holds the item codes, register indexes and fixed field widths.
// No dependencies; every other file of the block imports it.
package bbpd_pkg;

	// Fixed widths of the configuration port and the result coordinates.
	localparam int CFG_DATA_W = 11;
	localparam int CFG_INDEX_W = 1;
	localparam int COORD_W = 10;

	// Default size limits and the dimension loaded at reset.
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DIM_RESET = 1024;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Item kinds carried on the mode field.
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

endpackage

/* src/bbpd_line_store.sv */
// One-bit-wide line memory with one write port and one registered read port.
// Write-first: a read at the address being written returns the new bit.
// Imports bbpd_pkg but uses none of its items.
module bbpd_line_store #(
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);
	import bbpd_pkg::*;

	localparam int DEPTH = 1 << AW;

	logic mem [DEPTH];
	logic rdata_q;

	// Storage write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read with bypass of a same-cycle write.
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/binary_boundary_pixel_detector.sv */
// Binary inner boundary detector (4-connected) for a raster-order pixel stream.
// It takes one pixel per cycle and gives at most one result per cycle: the
// decision for a pixel appears when the pixel below it is transferred, one row
// late, with its column and row. After width*height pixels, one flush item per
// column gives the last row; the final one carries frame_last. Flush items that
// come early and pixels that come after the frame ends give no result. The line
// memories are read one column ahead into registers, so an item can follow in
// the very next cycle. A result is offered from the result register in the cycle
// after its item's transfer; while it waits, the input is held, and a new item is
// taken at the earliest in the cycle that the waiting result is transferred.
// Writing either register restarts the frame.
module binary_boundary_pixel_detector #(
	parameter int MAX_WIDTH = bbpd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bbpd_pkg::DEF_MAX_HEIGHT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bbpd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bbpd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              mode,
	input  logic                              pixel,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bbpd_pkg::COORD_W-1:0]      col,
	output logic [bbpd_pkg::COORD_W-1:0]      row,
	output logic                              is_boundary,
	output logic                              frame_last
);
	import bbpd_pkg::*;

	// Counter and dimension widths.
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int EW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
	localparam int EH = (RW > CFG_DATA_W) ? RW : CFG_DATA_W;
	localparam int W_RST = (MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET;
	localparam int H_RST = (MAX_HEIGHT < DIM_RESET) ? MAX_HEIGHT : DIM_RESET;

	logic [WW-1:0] width_q;
	logic [RW-1:0] height_q;
	logic [CW-1:0] cnt_col_q;
	logic [RW-1:0] cnt_row_q;
	logic          left_q;

	logic          out_valid_q;
	logic [COORD_W-1:0] res_col_q;
	logic [COORD_W-1:0] res_row_q;
	logic          res_bnd_q;
	logic          res_last_q;

	logic [EW-1:0] cfg_w_ext;
	logic [EH-1:0] cfg_h_ext;
	logic [WW-1:0] width_clamped;
	logic [RW-1:0] height_clamped;

	logic          rd_cen;
	logic          rd_rgt;
	logic          rd_up;

	logic          in_xfer;
	logic          frame_item;
	logic          in_frame;
	logic [WW-1:0] col_inc;
	logic          col_ok;
	logic          has_right;
	logic          act_px;
	logic          act_fl;
	logic          emit;
	logic          nb_up;
	logic          nb_left;
	logic          nb_right;
	logic          bnd;
	logic          restart;
	logic [CW-1:0] col_nxt;
	logic [RW-1:0] row_nxt;
	logic          left_nxt;
	logic          store_we;
	logic [CW-1:0] raddr_rgt;

	// Bring written dimensions into the supported range.
	always_comb begin
		cfg_w_ext = EW'(cfg_data);
		cfg_h_ext = EH'(cfg_data);
		if (cfg_w_ext == '0) begin
			width_clamped = WW'(1);
		end else if (cfg_w_ext > EW'(MAX_WIDTH)) begin
			width_clamped = WW'(MAX_WIDTH);
		end else begin
			width_clamped = WW'(cfg_w_ext);
		end
		if (cfg_h_ext == '0) begin
			height_clamped = RW'(1);
		end else if (cfg_h_ext > EH'(MAX_HEIGHT)) begin
			height_clamped = RW'(MAX_HEIGHT);
		end else begin
			height_clamped = RW'(cfg_h_ext);
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WW'(W_RST);
			height_q <= RW'(H_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= width_clamped;
				REG_IMAGE_HEIGHT: height_q <= height_clamped;
			endcase
		end
	end

	// Item classification and the boundary decision.
	always_comb begin
		in_ready = !out_valid_q || out_ready;
		in_xfer = in_valid && in_ready;
		frame_item = (mode == MODE_PIXEL);
		in_frame = cnt_row_q < height_q;
		col_inc = WW'(cnt_col_q) + WW'(1);
		col_ok = WW'(cnt_col_q) < width_q;
		has_right = col_inc < width_q;
		act_px = frame_item && in_frame && col_ok;
		act_fl = !frame_item && !in_frame && col_ok;
		emit = act_px ? (cnt_row_q != '0) : act_fl;
		nb_up = (cnt_row_q > RW'(1)) && rd_up;
		nb_left = (cnt_col_q != '0) && left_q;
		nb_right = has_right && rd_rgt;
		// On the last row the pixel below lies outside, so a set pixel is boundary.
		if (act_px) begin
			bnd = rd_cen && !(nb_up && pixel && nb_left && nb_right);
		end else begin
			bnd = rd_cen;
		end
	end

	// Next counter values; they also address the look-ahead reads.
	always_comb begin
		restart = cfg_we || (in_xfer && act_fl && !has_right);
		col_nxt = cnt_col_q;
		row_nxt = cnt_row_q;
		left_nxt = left_q;
		if (restart) begin
			col_nxt = '0;
			row_nxt = '0;
			left_nxt = 1'b0;
		end else if (in_xfer && (act_px || act_fl)) begin
			col_nxt = has_right ? CW'(col_inc) : '0;
			if (act_px) begin
				left_nxt = rd_cen;
				if (!has_right) begin
					row_nxt = cnt_row_q + RW'(1);
				end
			end
		end
		store_we = in_xfer && act_px;
		raddr_rgt = col_nxt + CW'(1);
	end

	// Frame position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_col_q <= '0;
			cnt_row_q <= '0;
			left_q <= 1'b0;
		end else begin
			cnt_col_q <= col_nxt;
			cnt_row_q <= row_nxt;
			left_q <= left_nxt;
		end
	end

	// Most recent row, read at the current column.
	bbpd_line_store #(.AW(CW)) u_recent_cen (
		.clk   (clk),
		.we    (store_we),
		.waddr (cnt_col_q),
		.wdata (pixel),
		.raddr (col_nxt),
		.rdata (rd_cen)
	);

	// Copy of the most recent row, read one column to the right.
	bbpd_line_store #(.AW(CW)) u_recent_rgt (
		.clk   (clk),
		.we    (store_we),
		.waddr (cnt_col_q),
		.wdata (pixel),
		.raddr (raddr_rgt),
		.rdata (rd_rgt)
	);

	// Older row, refilled from the most recent row as it is overwritten.
	bbpd_line_store #(.AW(CW)) u_older (
		.clk   (clk),
		.we    (store_we),
		.waddr (cnt_col_q),
		.wdata (rd_cen),
		.raddr (col_nxt),
		.rdata (rd_up)
	);

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (in_xfer && emit) begin
			res_col_q <= COORD_W'(cnt_col_q);
			res_row_q <= COORD_W'(cnt_row_q - RW'(1));
			res_bnd_q <= bnd;
			res_last_q <= act_fl && !has_right;
		end
	end

	assign out_valid = out_valid_q;
	assign col = res_col_q;
	assign row = res_row_q;
	assign is_boundary = res_bnd_q;
	assign frame_last = res_last_q;

endmodule

/* src/bbpd_checker.sv */
// Port-level checker for the binary boundary pixel detector, bound to the top.
// Depends on bbpd_pkg for the field widths.
module bbpd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [bbpd_pkg::COORD_W-1:0]      col,
	input logic [bbpd_pkg::COORD_W-1:0]      row,
	input logic                              is_boundary,
	input logic                              frame_last
);
	import bbpd_pkg::*;

	// A waiting result keeps its payload until its transfer.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(col) && $stable(row)
			&& $stable(is_boundary) && $stable(frame_last))
		else $error("result changed while stalled");

	// With no result pending the input side is open.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// A result leaves and no item enters: nothing may appear next.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
		else $error("result appeared without an input transfer");

	// A result can only appear after an input transfer.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !(in_valid && in_ready) |=> !out_valid)
		else $error("result appeared from an idle block");

endmodule

bind binary_boundary_pixel_detector bbpd_checker u_bbpd_checker (.*);
